// File: rtl/core/lxd_pkg.sv
// Types and constants shared by the light exposure detector and its checker.
`default_nettype none

package lxd_pkg;

  // Reported light state of one result item.
  typedef enum logic [1:0] {
    ST_DARK    = 2'd0,
    ST_AMBIENT = 2'd1,
    ST_BRIGHT  = 2'd2,
    ST_FAULT   = 2'd3
  } light_state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_DARK_LEVEL       = 3'd0;
  localparam logic [2:0] REG_ENTER_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_EXIT_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_CONFIRM_TIME     = 3'd3;
  localparam logic [2:0] REG_EXIT_HOLD_TIME   = 3'd4;
  localparam logic [2:0] REG_CREDIT_INTERVAL  = 3'd5;
  localparam logic [2:0] REG_SENSOR_MAXIMUM   = 3'd6;

  localparam logic [15:0] SENSOR_MAXIMUM_RESET = 16'd4095;

  // Microseconds per millisecond, and the elapsed time at which the
  // millisecond count no longer fits in 32 bits (1000 * 2^32).
  localparam logic [9:0]  US_PER_MS   = 10'd1000;
  localparam logic [41:0] US_SAT      = 42'd4294967296000;
  localparam logic [11:0] US_PER_MS_2 = 12'd2000;

  // floor(2^32 * 1024 / 1000): the elapsed time shifted right by 10 and
  // multiplied by this gives an estimate at most two below the true quotient.
  localparam logic [32:0] MS_RECIP = 33'd4398046511;

  // Side information that travels with an item down the divider stages.
  typedef struct packed {
    light_state_t state;
    logic [15:0]  level;
    logic         masked;
    logic         credit;
    logic         calc;
    logic         sat;
  } item_meta_t;

endpackage

`default_nettype wire

// File: rtl/core/light_exposure_detector.sv
// Light exposure detector: classification, exposure timing and millisecond divider.
`default_nettype none

// Usage
// The block takes one timestamped light sample per item on the s_axis channel
// and returns one result item per sample on the m_axis channel, in order.
// An accepted item is first held in an input register. When it moves on, the
// classification, confirmation timers, exposure start and credit timing are
// updated as stage 1 loads, so the next sample sees them right away. The elapsed
// exposure time is then turned into milliseconds by a three-stage divider:
// a 32x33 reciprocal multiply, a back-multiply by 1000 with subtraction, and a
// final correction of up to two. An accepted item passes from the input
// register through stage 1, stages 2 and 3 and the output register; the block
// takes one item per cycle while the receiver does not stall.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so when the receiver stalls, items keep filling empty
// stages and the input is refused only once all five registers hold items.
// The config channel writes one register per handshake and is always ready;
// it should be used only while no item is in flight. An index beyond the
// register list is ignored.
// Reset (rst, synchronous, active high) empties the pipeline, returns the
// light state to dark, drops all pending confirmations and restores the
// register defaults (all zero, sensor maximum 4095).

module light_exposure_detector
  import lxd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // Sample channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // [63:0] time_now, [79:64] level
  input  wire logic [1:0]  s_axis_tuser,  // [0] sample_valid, [1] masked

  // Result channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // [1:0] light_state, [17:2] shown_level,
                                          // [49:18] bright_ms, [55:50] zero
  output logic [1:0]       m_axis_tuser,  // [0] masked_echo, [1] credit

  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers.
  logic [15:0] dark_level;
  logic [15:0] enter_threshold;
  logic [15:0] exit_threshold;
  logic [31:0] confirm_time;
  logic [31:0] exit_hold_time;
  logic [31:0] credit_interval;
  logic [15:0] sensor_maximum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_level      <= '0;
      enter_threshold <= '0;
      exit_threshold  <= '0;
      confirm_time    <= '0;
      exit_hold_time  <= '0;
      credit_interval <= '0;
      sensor_maximum  <= SENSOR_MAXIMUM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DARK_LEVEL:      dark_level      <= cfg_data[15:0];
        REG_ENTER_THRESHOLD: enter_threshold <= cfg_data[15:0];
        REG_EXIT_THRESHOLD:  exit_threshold  <= cfg_data[15:0];
        REG_CONFIRM_TIME:    confirm_time    <= cfg_data;
        REG_EXIT_HOLD_TIME:  exit_hold_time  <= cfg_data;
        REG_CREDIT_INTERVAL: credit_interval <= cfg_data;
        REG_SENSOR_MAXIMUM:  sensor_maximum  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance enables. A stage loads when it is empty or
  // when its current item moves on.
  logic v0, v1, v2, v3, vo;
  logic en0, en1, en2, en3, eno;

  assign eno = !vo || m_axis_tready;
  assign en3 = !v3 || eno;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign s_axis_tready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en0) v0 <= s_axis_tvalid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (eno) vo <= v3;
    end
  end

  // Input register.
  logic [63:0] in_time;
  logic [15:0] in_level;
  logic        in_sample_valid;
  logic        in_masked;

  always_ff @(posedge clk) begin
    if (en0 && s_axis_tvalid) begin
      in_time         <= s_axis_tdata[63:0];
      in_level        <= s_axis_tdata[79:64];
      in_sample_valid <= s_axis_tuser[0];
      in_masked       <= s_axis_tuser[1];
    end
  end

  // Detector state.
  light_state_t mode, mode_next;
  logic         enter_pending, enter_pending_next;
  logic [63:0]  enter_since, enter_since_next;
  logic         exit_pending, exit_pending_next;
  logic [63:0]  exit_since, exit_since_next;
  logic [63:0]  exposure_start, exposure_start_next;
  logic [63:0]  last_credit_time, last_credit_time_next;

  logic         fault;
  logic         enter_ok;
  logic         exit_ok;
  logic         credit_due;
  light_state_t calm_state;
  logic [63:0]  elapsed;
  item_meta_t   meta_next;

  assign fault      = !in_sample_valid || (in_level > sensor_maximum);
  assign calm_state = (in_level <= dark_level) ? ST_DARK : ST_AMBIENT;
  assign elapsed    = in_time - exposure_start;

  // A confirmation that starts on this sample has zero elapsed time, so it
  // completes at once only when the required time is zero.
  assign enter_ok = enter_pending ? ((in_time - enter_since) >= {32'd0, confirm_time})
                                  : (confirm_time == '0);
  assign exit_ok  = exit_pending ? ((in_time - exit_since) >= {32'd0, exit_hold_time})
                                 : (exit_hold_time == '0);
  assign credit_due = (credit_interval != '0) &&
                      ((in_time - last_credit_time) >= {32'd0, credit_interval});

  always_comb begin
    mode_next             = mode;
    enter_pending_next    = enter_pending;
    enter_since_next      = enter_since;
    exit_pending_next     = exit_pending;
    exit_since_next       = exit_since;
    exposure_start_next   = exposure_start;
    last_credit_time_next = last_credit_time;

    meta_next.state  = mode;
    meta_next.level  = in_level;
    meta_next.masked = in_masked;
    meta_next.credit = 1'b0;
    meta_next.calc   = 1'b0;
    meta_next.sat    = (elapsed[63:42] != '0) || (elapsed[41:0] >= US_SAT);

    priority if (fault) begin
      mode_next             = ST_FAULT;
      meta_next.level       = '0;
      enter_pending_next    = 1'b0;
      exit_pending_next     = 1'b0;
      exposure_start_next   = '0;
      last_credit_time_next = '0;
    end else if (in_masked) begin
      // Own light may reach the sensor: drop confirmations and, while
      // bright, restart the exposure timing here.
      enter_pending_next = 1'b0;
      exit_pending_next  = 1'b0;
      if (mode == ST_BRIGHT) begin
        exposure_start_next   = in_time;
        last_credit_time_next = in_time;
      end
    end else if (mode != ST_BRIGHT) begin
      mode_next = calm_state;
      if (in_level >= enter_threshold) begin
        if (!enter_pending) begin
          enter_pending_next = 1'b1;
          enter_since_next   = in_time;
        end
        if (enter_ok) begin
          mode_next             = ST_BRIGHT;
          exposure_start_next   = in_time;
          last_credit_time_next = in_time;
          enter_pending_next    = 1'b0;
        end
      end else begin
        enter_pending_next = 1'b0;
      end
    end else if ((in_level <= exit_threshold) && exit_ok) begin
      // Exit confirmed: back to a calm state with the exposure cleared.
      mode_next             = calm_state;
      enter_pending_next    = 1'b0;
      exit_pending_next     = 1'b0;
      exposure_start_next   = '0;
      last_credit_time_next = '0;
    end else begin
      if (in_level <= exit_threshold) begin
        if (!exit_pending) begin
          exit_pending_next = 1'b1;
          exit_since_next   = in_time;
        end
      end else begin
        exit_pending_next = 1'b0;
      end
      meta_next.calc = 1'b1;
      if (credit_due) begin
        meta_next.credit      = 1'b1;
        last_credit_time_next = in_time;
      end
    end

    meta_next.state = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= ST_DARK;
      enter_pending    <= 1'b0;
      enter_since      <= '0;
      exit_pending     <= 1'b0;
      exit_since       <= '0;
      exposure_start   <= '0;
      last_credit_time <= '0;
    end else if (en1 && v0) begin
      mode             <= mode_next;
      enter_pending    <= enter_pending_next;
      enter_since      <= enter_since_next;
      exit_pending     <= exit_pending_next;
      exit_since       <= exit_since_next;
      exposure_start   <= exposure_start_next;
      last_credit_time <= last_credit_time_next;
    end
  end

  // Stage 1: classified item and elapsed exposure time.
  item_meta_t  meta1;
  logic [41:0] span1;

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      meta1 <= meta_next;
      span1 <= elapsed[41:0];
    end
  end

  // Stage 2: reciprocal product estimating span / 1000.
  item_meta_t  meta2;
  logic [41:0] span2;
  logic [64:0] prod2;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      meta2 <= meta1;
      span2 <= span1;
      prod2 <= 65'(span1[41:10]) * 65'(MS_RECIP);
    end
  end

  // Stage 3: estimate and remainder; the remainder stays below 3000.
  item_meta_t  meta3;
  logic [31:0] quot3;
  logic [11:0] rem3;
  logic [41:0] back3;
  logic [41:0] diff3;

  assign back3 = 42'(prod2[63:32]) * 42'(US_PER_MS);
  assign diff3 = span2 - back3;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      meta3 <= meta2;
      quot3 <= prod2[63:32];
      rem3  <= diff3[11:0];
    end
  end

  // Output stage: zeroing of items without a duration, correction, saturation and result register.
  item_meta_t  meta_o;
  logic [31:0] ms_o;
  logic [31:0] ms_next;

  always_comb begin
    priority if (!meta3.calc) begin
      ms_next = '0;
    end else if (meta3.sat) begin
      ms_next = '1;
    end else if (rem3 >= US_PER_MS_2) begin
      ms_next = quot3 + 32'd2;
    end else if (rem3 >= 12'(US_PER_MS)) begin
      ms_next = quot3 + 32'd1;
    end else begin
      ms_next = quot3;
    end
  end

  always_ff @(posedge clk) begin
    if (eno && v3) begin
      meta_o <= meta3;
      ms_o   <= ms_next;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {6'd0, ms_o, meta_o.level, meta_o.state};
  assign m_axis_tuser  = {meta_o.credit, meta_o.masked};

endmodule

`default_nettype wire

// File: rtl/core/lxd_checker.sv
// Port-level checker for the light exposure detector, bound to the top level.
`default_nettype none

module lxd_checker
  import lxd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // Duration is only reported during bright exposure.
  a_ms_only_bright: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_BRIGHT)) |-> (m_axis_tdata[49:18] == '0))
    else $error("bright_ms nonzero outside bright exposure");

  // Credits are only given during bright exposure.
  a_credit_only_bright: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[1:0] == ST_BRIGHT))
    else $error("credit outside bright exposure");

  // A masked sample never earns a credit.
  a_credit_unmasked: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
    else $error("credit on a masked sample");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind light_exposure_detector lxd_checker u_lxd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
